// ===== sv/gaussian_pdf_fixed_point_defines.svh =====
// ============================================================================
// Gaussian PDF assertion macros
// Shared concurrent assertion forms for the Gaussian density pipeline.
// ============================================================================
`ifndef GAUSSIAN_PDF_FIXED_POINT_DEFINES_SVH
`define GAUSSIAN_PDF_FIXED_POINT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define GPF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gpf assertion failed");

// next-cycle implication, disabled in reset
`define GPF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gpf assertion failed");

`endif

// ===== sv/gpf_pkg.sv =====
// ============================================================================
// Gaussian PDF package
// Shared job type and fixed-point product helper.
// ============================================================================
`default_nettype none

package gpf_pkg;

    // classified request passed from front to back
    typedef struct packed {
        logic signed [31:0] xm2;
        logic signed [31:0] den;
        logic signed [31:0] divisor;
        logic               fault;
    } t_job;

    // sqrt(2*pi) in Q32
    localparam logic [33:0] SQRT_2PI_Q32 = 34'd10765886462;

    // (a >>> h) * (b >>> h), wrapped to 32 bits
    function automatic logic signed [31:0] fmul(input logic signed [31:0] a,
                                                input logic signed [31:0] b,
                                                input int unsigned h);
        logic signed [31:0] sa;
        logic signed [31:0] sb;
        sa = a >>> h;
        sb = b >>> h;
        return sa * sb;
    endfunction

endpackage

`default_nettype wire

// ===== sv/gpf_fifo.sv =====
// ============================================================================
// Gaussian PDF queue
// Small synchronous FIFO with count, used between stages and at the output.
// ============================================================================
`default_nettype none

`include "gaussian_pdf_fixed_point_defines.svh"

module gpf_fifo #(
    parameter int DEPTH = 4,
    parameter int W     = 8
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_push,
    input  wire logic [W-1:0]               i_data,
    input  wire logic                       i_pop,
    output logic [W-1:0]                    o_data,
    output logic                            o_empty,
    output logic                            o_full,
    output logic [$clog2(DEPTH+1)-1:0]      o_count
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH+1);

    logic [W-1:0]  r_mem [0:DEPTH-1];
    logic [AW-1:0] r_wp, n_wp, r_rp, n_rp;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          w_wr, w_rd;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_count = r_cnt;
    assign o_data  = r_mem[r_rp];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;

    // pointer and count update
    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (w_wr) begin
            n_wp = (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
        end
        if (w_rd) begin
            n_rp = (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
        end
        if (w_wr && !w_rd) begin
            n_cnt = r_cnt + 1'b1;
        end else if (w_rd && !w_wr) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // storage write
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

    `GPF_ASSERT_IMPL(a_no_overflow, i_clk, i_rst_n, i_push, !o_full)
    `GPF_ASSERT_NEXT(a_count_up, i_clk, i_rst_n, w_wr && !w_rd, r_cnt == $past(r_cnt) + 1'b1)
    `GPF_ASSERT_NEXT(a_count_down, i_clk, i_rst_n, w_rd && !w_wr, r_cnt == $past(r_cnt) - 1'b1)

endmodule

`default_nettype wire

// ===== sv/gpf_front.sv =====
// ============================================================================
// Gaussian PDF front end
// Takes requests, forms the squared terms and flags zero divisors.
// ============================================================================
`default_nettype none

module gpf_front #(
    parameter int FRAC = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_take,
    input  wire logic signed [31:0]  i_sample,
    input  wire logic signed [31:0]  i_mean_value,
    input  wire logic [30:0]         i_std_dev,
    output logic                     o_vld,
    output gpf_pkg::t_job            o_job,
    output logic [1:0]               o_busy
);
    localparam int unsigned H = FRAC / 2;
    localparam logic signed [31:0] SQRT2PI = 32'(gpf_pkg::SQRT_2PI_Q32 >> (32 - FRAC));

    logic               r_v0, r_v1;
    logic signed [31:0] r_diff, r_sd;
    logic signed [31:0] r_std2, r_xm2, r_divisor;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else begin
            r_v0 <= i_take;
            r_v1 <= r_v0;
        end
    end

    // difference, then three products
    always_ff @(posedge i_clk) begin
        r_diff    <= i_sample - i_mean_value;
        r_sd      <= {1'b0, i_std_dev};
        r_std2    <= gpf_pkg::fmul(r_sd, r_sd, H);
        r_xm2     <= gpf_pkg::fmul(r_diff, r_diff, H);
        r_divisor <= gpf_pkg::fmul(SQRT2PI, r_sd, H);
    end

    // classify
    always_comb begin
        o_job.xm2     = r_xm2;
        o_job.den     = {r_std2[30:0], 1'b0};
        o_job.divisor = r_divisor;
        o_job.fault   = (o_job.den == '0) || (r_divisor == '0);
    end

    assign o_vld  = r_v1;
    assign o_busy = {1'b0, r_v0} + {1'b0, r_v1};

endmodule

`default_nettype wire

// ===== sv/gpf_div.sv =====
// ============================================================================
// Gaussian PDF divider
// Pipelined restoring divide of (a << FRAC) by b, rounded half away from zero.
// ============================================================================
`default_nettype none

module gpf_div #(
    parameter int FRAC = 16,
    parameter int SW   = 1
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_en,
    input  wire logic                i_vld,
    input  wire logic signed [31:0]  i_a,
    input  wire logic signed [31:0]  i_b,
    input  wire logic [SW-1:0]       i_side,
    output logic                     o_vld,
    output logic signed [31:0]       o_q,
    output logic [SW-1:0]            o_side
);
    localparam int W = 32 + FRAC;

    logic [W-1:0]  r_dvd  [0:W];
    logic [31:0]   r_rem  [0:W];
    logic [31:0]   r_d    [0:W];
    logic          r_neg  [0:W];
    logic [SW-1:0] r_side [0:W];
    logic          r_vld  [0:W];

    logic [31:0] w_amag, w_bmag, w_q;

    // magnitudes and rounding offset
    assign w_amag = i_a[31] ? 32'(-i_a) : 32'(i_a);
    assign w_bmag = i_b[31] ? 32'(-i_b) : 32'(i_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dvd[0]  <= {w_amag, FRAC'(0)} + W'(w_bmag >> 1);
            r_rem[0]  <= '0;
            r_d[0]    <= w_bmag;
            r_neg[0]  <= i_a[31] ^ i_b[31];
            r_side[0] <= i_side;
        end
    end

    // one quotient bit per stage
    for (genvar k = 1; k <= W; k++) begin : g_stage
        logic [32:0] w_tmp, w_sub;
        logic        w_ge;
        assign w_tmp = {r_rem[k-1], r_dvd[k-1][W-1]};
        assign w_sub = w_tmp - {1'b0, r_d[k-1]};
        assign w_ge  = (w_tmp >= {1'b0, r_d[k-1]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= r_vld[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= w_ge ? w_sub[31:0] : w_tmp[31:0];
                r_dvd[k]  <= {r_dvd[k-1][W-2:0], w_ge};
                r_d[k]    <= r_d[k-1];
                r_neg[k]  <= r_neg[k-1];
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // signed, wrapped quotient
    assign w_q    = r_dvd[W][31:0];
    assign o_q    = r_neg[W] ? -w_q : w_q;
    assign o_vld  = r_vld[W];
    assign o_side = r_side[W];

endmodule

`default_nettype wire

// ===== sv/gpf_back.sv =====
// ============================================================================
// Gaussian PDF back end
// Exponent divide, exp by eight squarings, normalizing divide and clamp.
// ============================================================================
`default_nettype none

module gpf_back #(
    parameter int FRAC = 16
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_vld,
    input  wire gpf_pkg::t_job   i_job,
    input  wire logic            i_out_full,
    output logic                 o_take,
    output logic                 o_push,
    output logic signed [31:0]   o_density,
    output logic                 o_fault
);
    localparam int Q = FRAC + 8;
    localparam int unsigned QH = Q / 2;
    localparam logic signed [31:0] FLOOR_LIM = -(32'sd9 <<< FRAC);
    localparam logic signed [31:0] TINY = 32'((64'd1 << FRAC) / 10000);
    localparam logic signed [31:0] EXP_ONE = 32'(64'd1 << Q);

    logic               w_en;
    logic               w_v1, w_v2;
    logic signed [31:0] w_q1, w_q2, w_expo;
    logic [32:0]        w_s1;
    logic [1:0]         w_s2;

    logic               r_ev  [0:8];
    logic signed [31:0] r_x   [0:8];
    logic signed [31:0] r_dv  [0:8];
    logic               r_cl  [0:8];
    logic               r_ft  [0:8];

    // whole back pipe moves together unless a result is waiting and the result queue is full
    assign w_en   = !w_v2 || !i_out_full;
    assign o_take = i_vld && w_en;

    gpf_div #(.FRAC(FRAC), .SW(33)) u_div_expo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (i_vld),
        .i_a     (i_job.xm2),
        .i_b     (i_job.den),
        .i_side  ({i_job.divisor, i_job.fault}),
        .o_vld   (w_v1),
        .o_q     (w_q1),
        .o_side  (w_s1)
    );

    assign w_expo = -w_q1;

    // exp seed and clamp flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ev[0] <= 1'b0;
        end else if (w_en) begin
            r_ev[0] <= w_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_x[0]  <= w_expo + EXP_ONE;
            r_cl[0] <= (w_expo < FLOOR_LIM);
            r_dv[0] <= w_s1[32:1];
            r_ft[0] <= w_s1[0];
        end
    end

    // eight squaring stages
    for (genvar k = 1; k <= 8; k++) begin : g_sq
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ev[k] <= 1'b0;
            end else if (w_en) begin
                r_ev[k] <= r_ev[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_x[k]  <= gpf_pkg::fmul(r_x[k-1], r_x[k-1], QH);
                r_cl[k] <= r_cl[k-1];
                r_dv[k] <= r_dv[k-1];
                r_ft[k] <= r_ft[k-1];
            end
        end
    end

    gpf_div #(.FRAC(FRAC), .SW(2)) u_div_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_ev[8]),
        .i_a     (r_x[8] >>> 8),
        .i_b     (r_dv[8]),
        .i_side  ({r_cl[8], r_ft[8]}),
        .o_vld   (w_v2),
        .o_q     (w_q2),
        .o_side  (w_s2)
    );

    // fault and clamp select
    always_comb begin
        if (w_s2[0]) begin
            o_density = '0;
        end else if (w_s2[1]) begin
            o_density = TINY;
        end else begin
            o_density = w_q2;
        end
    end

    assign o_fault = w_s2[0];
    assign o_push  = w_v2 && w_en;

endmodule

`default_nettype wire

// ===== sv/gaussian_pdf_fixed_point.sv =====
// Pipeline: two bit-per-stage dividers of 32+FRACTION_BITS stages each,
//   with the exp squaring stages between them.
// Throughput: one request per cycle while results are popped.
// Reset: synchronous active-low i_rst_n clears all valid bits and queues;
//   payload registers are not reset.
// ============================================================================
// Gaussian PDF top level
// Fixed-point Gaussian density with decoupled front end and back end.
// ============================================================================
`default_nettype none

module gaussian_pdf_fixed_point #(
    parameter int FRACTION_BITS = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                push,
    output logic                     full,
    input  wire logic signed [31:0]  i_sample,
    input  wire logic signed [31:0]  i_mean_value,
    input  wire logic [30:0]         i_std_dev,
    output logic                     empty,
    input  wire logic                pop,
    output logic signed [31:0]       o_density,
    output logic                     o_divide_fault
);
    localparam int QD = 4;
    localparam int CW = $clog2(QD + 1);

    logic               w_take;
    logic               w_fvld;
    gpf_pkg::t_job      w_fjob, w_bjob;
    logic [1:0]         w_busy;
    logic               w_q_empty, w_q_full, w_q_pop;
    logic [CW-1:0]      w_q_cnt;
    logic               w_o_full, w_o_push;
    logic [CW-1:0]      w_o_cnt;
    logic signed [31:0] w_den;
    logic               w_fault;
    logic [32:0]        w_ohead;

    // credit: queue room covers requests still in the front stages
    assign full   = ({1'b0, w_q_cnt} + (CW+1)'(w_busy)) >= (CW+1)'(QD);
    assign w_take = push && !full;

    gpf_front #(.FRAC(FRACTION_BITS)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (w_take),
        .i_sample     (i_sample),
        .i_mean_value (i_mean_value),
        .i_std_dev    (i_std_dev),
        .o_vld        (w_fvld),
        .o_job        (w_fjob),
        .o_busy       (w_busy)
    );

    gpf_fifo #(.DEPTH(QD), .W($bits(gpf_pkg::t_job))) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_fvld),
        .i_data  (w_fjob),
        .i_pop   (w_q_pop),
        .o_data  (w_bjob),
        .o_empty (w_q_empty),
        .o_full  (w_q_full),
        .o_count (w_q_cnt)
    );

    gpf_back #(.FRAC(FRACTION_BITS)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_vld      (!w_q_empty),
        .i_job      (w_bjob),
        .i_out_full (w_o_full),
        .o_take     (w_q_pop),
        .o_push     (w_o_push),
        .o_density  (w_den),
        .o_fault    (w_fault)
    );

    gpf_fifo #(.DEPTH(QD), .W(33)) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_o_push),
        .i_data  ({w_den, w_fault}),
        .i_pop   (pop),
        .o_data  (w_ohead),
        .o_empty (empty),
        .o_full  (w_o_full),
        .o_count (w_o_cnt)
    );

    assign o_density      = w_ohead[32:1];
    assign o_divide_fault = w_ohead[0] && (w_o_cnt != '0) && !w_q_full | w_ohead[0];

endmodule

`default_nettype wire
